@@ design/murmur3_32_stream_hash_assert.svh @@
// Assertion macros for the MurmurHash3 stream hasher checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef MURMUR3_32_STREAM_HASH_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_ASSERT_SVH

// Check a property at each rising edge outside of reset.
`define MM3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define MM3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mm3_pkg.sv @@
// Shared constants and types of the MurmurHash3 stream hasher.
// No dependencies; the cfg, ctrl, dp, top and checker files import this package.
package mm3_pkg;

  // Mixing constants of MurmurHash3 x86_32.
  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;

  // Register port: one 32-bit register at byte address 0.
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_HASH_SEED = '0;

  // Datapath commands.
  typedef logic [2:0] mm3_op_t;
  localparam mm3_op_t OP_NOP   = 3'd0;
  localparam mm3_op_t OP_TAKE  = 3'd1;  // merge the request into the state
  localparam mm3_op_t OP_KMUL1 = 3'd2;  // k = block * C1
  localparam mm3_op_t OP_KMUL2 = 3'd3;  // k = rotl15(k) * C2
  localparam mm3_op_t OP_MIXH  = 3'd4;  // h = rotl13(h ^ k) * 5 + ADD
  localparam mm3_op_t OP_FMUL1 = 3'd5;  // first finalizer multiply
  localparam mm3_op_t OP_FMUL2 = 3'd6;  // second finalizer multiply
  localparam mm3_op_t OP_EMIT  = 3'd7;  // last shift-xor into the output

  typedef struct packed {
    mm3_op_t op;
    logic    use_tail;  // fold the scrambled tail into the finalizer
  } mm3_cmd_t;

  typedef struct packed {
    logic [1:0] cnt_lo;  // bytes in the open block, zero between messages
  } mm3_stat_t;

endpackage

@@ design/mm3_if.sv @@
// Valid/ready channel interfaces of the MurmurHash3 stream hasher.
// Standalone; no package needed.
interface mm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

@@ design/mm3_cfg.sv @@
// APB-style register port holding the hash seed.
// Depends on mm3_pkg.
module mm3_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mm3_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 seed
);
  import mm3_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] seed_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    seed_nxt = seed_r;
    if (wr_en && paddr == REG_HASH_SEED) begin
      seed_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  assign prdata = (paddr == REG_HASH_SEED) ? seed_r : '0;
  assign seed   = seed_r;

endmodule

@@ design/mm3_ctrl.sv @@
// Controller of the MurmurHash3 stream hasher: sequences the datapath
// and owns both handshakes. Depends on mm3_pkg.
module mm3_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_present,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mm3_pkg::mm3_stat_t stat,
  output mm3_pkg::mm3_cmd_t  cmd
);
  import mm3_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KMUL1 = 4'd1;
  localparam logic [3:0] S_KMUL2 = 4'd2;
  localparam logic [3:0] S_MIXH  = 4'd3;
  localparam logic [3:0] S_TMUL1 = 4'd4;
  localparam logic [3:0] S_TMUL2 = 4'd5;
  localparam logic [3:0] S_FMUL1 = 4'd6;
  localparam logic [3:0] S_FMUL2 = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       tail_r, tail_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] cnt_after;

  // Bytes in the open block once this request is merged.
  assign cnt_after = stat.cnt_lo + {1'b0, in_present};

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op        = OP_NOP;
    cmd.use_tail  = tail_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // Requests with neither a byte nor an end are taken and dropped.
        if (in_valid && (in_present || in_last)) begin
          cmd.op   = OP_TAKE;
          last_nxt = in_last;
          tail_nxt = (cnt_after != 2'd0);
          if (in_present && cnt_after == 2'd0) begin
            state_nxt = S_KMUL1;
          end else if (in_last) begin
            state_nxt = (cnt_after != 2'd0) ? S_TMUL1 : S_FMUL1;
          end
        end
      end
      S_KMUL1: begin
        cmd.op    = OP_KMUL1;
        state_nxt = S_KMUL2;
      end
      S_KMUL2: begin
        cmd.op    = OP_KMUL2;
        state_nxt = S_MIXH;
      end
      S_MIXH: begin
        cmd.op    = OP_MIXH;
        state_nxt = last_r ? S_FMUL1 : S_IDLE;
      end
      S_TMUL1: begin
        cmd.op    = OP_KMUL1;
        state_nxt = S_TMUL2;
      end
      S_TMUL2: begin
        cmd.op    = OP_KMUL2;
        state_nxt = S_FMUL1;
      end
      S_FMUL1: begin
        cmd.op    = OP_FMUL1;
        state_nxt = S_FMUL2;
      end
      S_FMUL2: begin
        cmd.op    = OP_FMUL2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/mm3_dp.sv @@
// Datapath of the MurmurHash3 stream hasher: running state, one shared
// 32x32 multiplier and the output register. Depends on mm3_pkg.
module mm3_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        seed,
  input  logic [7:0]         data_byte,
  input  logic               byte_present,
  input  mm3_pkg::mm3_cmd_t  cmd,
  output mm3_pkg::mm3_stat_t stat,
  output logic [31:0]        hash_value
);
  import mm3_pkg::*;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

  logic [31:0] h_r, h_nxt;
  logic [31:0] pb_r, pb_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic        in_msg_r, in_msg_nxt;

  logic [31:0] h_base, pb_base, cnt_base, pb_ins;
  logic [31:0] fin_x, fin_s, mix_x;
  logic [31:0] mul_a, mul_b, prod;

  // A message starts from the seed on its first request.
  assign h_base   = in_msg_r ? h_r   : seed;
  assign pb_base  = in_msg_r ? pb_r  : '0;
  assign cnt_base = in_msg_r ? cnt_r : '0;
  assign pb_ins   = pb_base | ({24'd0, data_byte} << {cnt_base[1:0], 3'b000});

  assign fin_x = h_r ^ (cmd.use_tail ? k_r : '0) ^ cnt_r;
  assign fin_s = fin_x ^ (fin_x >> 16);
  assign mix_x = rotl13(h_r ^ k_r);

  always_comb begin
    mul_a = pb_r;
    mul_b = MIX_C1;
    unique case (cmd.op)
      OP_KMUL2: begin
        mul_a = rotl15(k_r);
        mul_b = MIX_C2;
      end
      OP_FMUL1: begin
        mul_a = fin_s;
        mul_b = FMIX_M1;
      end
      OP_FMUL2: begin
        mul_a = k_r ^ (k_r >> 13);
        mul_b = FMIX_M2;
      end
      default: begin
        mul_a = pb_r;
        mul_b = MIX_C1;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    h_nxt      = h_r;
    pb_nxt     = pb_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    hash_nxt   = hash_r;
    in_msg_nxt = in_msg_r;
    unique case (cmd.op)
      OP_TAKE: begin
        h_nxt      = h_base;
        in_msg_nxt = 1'b1;
        pb_nxt     = byte_present ? pb_ins : pb_base;
        cnt_nxt    = cnt_base + {31'd0, byte_present};
      end
      OP_KMUL1, OP_KMUL2, OP_FMUL1, OP_FMUL2: begin
        k_nxt = prod;
      end
      OP_MIXH: begin
        h_nxt  = (mix_x << 2) + mix_x + MIX_ADD;
        pb_nxt = '0;
      end
      OP_EMIT: begin
        hash_nxt   = k_r ^ (k_r >> 16);
        in_msg_nxt = 1'b0;
      end
      default: begin
        h_nxt = h_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    pb_r   <= pb_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    hash_r <= hash_nxt;
  end

  assign stat.cnt_lo = in_msg_r ? cnt_r[1:0] : 2'd0;
  assign hash_value  = hash_r;

endmodule

@@ design/murmur3_32_stream_hash.sv @@
// MurmurHash3 x86_32 over a byte stream. Send one request per message byte
// (byte_present high); set message_end on the last one, or send a lone
// request with byte_present low and message_end high for an empty message.
// Each message starts from the seed at register 0 (byte address 0) as it
// stands on the message's first request, so a seed write mid-message takes
// effect from the next message. Requests with neither flag set are taken
// and ignored. A byte request is merged while the block is idle; when it
// completes a 4-byte block, the block scramble follows: it needs two
// dependent multiplies on the single shared 32x32 multiplier before the
// running hash is mixed. A message_end request adds finalization (two
// multiplies plus the output step), after a scramble of the 1-3 byte tail
// when there is one. The result sits in an output register; the block
// keeps taking requests while it waits and stalls only when a second hash
// is ready before the first was taken. Hash length is counted mod 2^32.
module murmur3_32_stream_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  mm3_in_if.sink                      in_ch,
  mm3_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mm3_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mm3_pkg::*;

  logic [31:0] seed;
  mm3_cmd_t    cmd;
  mm3_stat_t   stat;

  // Seed register behind the APB-style port.
  mm3_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  // Sequencer: request acceptance, block/tail/finalizer steps, result valid.
  mm3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_last    (in_ch.message_end),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hash state, shared multiplier and result register.
  mm3_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .seed         (seed),
    .data_byte    (in_ch.data_byte),
    .byte_present (in_ch.byte_present),
    .cmd          (cmd),
    .stat         (stat),
    .hash_value   (out_ch.hash_value)
  );

endmodule

@@ design/mm3_chk.sv @@
// Port-level checker for the MurmurHash3 stream hasher, bound to its top.
// Depends on mm3_pkg and murmur3_32_stream_hash_assert.svh.
`include "murmur3_32_stream_hash_assert.svh"

module mm3_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [31:0]                 hash_value,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mm3_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import mm3_pkg::*;

  logic seed_sel;
  logic seed_wr;
  logic out_stall;

  assign seed_sel  = (paddr == REG_HASH_SEED);
  assign seed_wr   = psel && penable && pwrite && seed_sel;
  assign out_stall = out_valid && !out_ready;

  `MM3_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  `MM3_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(hash_value), "stalled result changed")

  `MM3_ASSERT(a_end_busy, in_valid && in_ready && in_last |=> !in_ready, "taken while finalizing")

  `MM3_ASSERT(a_result_after_busy, $rose(out_valid) |-> !$past(in_ready), "result while idle")

  `MM3_ASSERT(a_seed_readback, seed_wr |=> !seed_sel || prdata == $past(pwdata), "seed readback")

endmodule

bind murmur3_32_stream_hash mm3_chk u_mm3_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.message_end),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hash_value (out_ch.hash_value),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready)
);
